/* src/qrm_pkg.sv */
package qrm_pkg;

  typedef enum logic {
    ACT_MULT = 1'b0,
    ACT_ROT  = 1'b1
  } action_e;

  localparam int unsigned CFG_IDX_BITS = 2;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_QUAT_X = 2'd0,
    REG_QUAT_Y = 2'd1,
    REG_QUAT_Z = 2'd2,
    REG_QUAT_W = 2'd3
  } cfg_reg_e;

  // Register stages between the input and the output port, output register included.
  localparam int unsigned PIPE_DEPTH = 5;

  typedef struct packed {
    logic    valid;
    action_e action;
  } stage_ctl_t;

  localparam stage_ctl_t CTL_IDLE = '{valid: 1'b0, action: ACT_MULT};

endpackage

/* src/qrm_front.sv */
module qrm_front
  import qrm_pkg::*;
#(
  parameter int WORD_BITS = 16,
  parameter int FRAC_BITS = 14,
  parameter int COEF_BITS = 20,
  parameter int ACC_BITS  = 38
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  stage_ctl_t                  in_ctl_i,
  output logic                        in_ready_o,
  input  logic signed [WORD_BITS-1:0] quat_i [4],
  input  logic signed [WORD_BITS-1:0] vec_i [4],
  output stage_ctl_t                  out_ctl_o,
  input  logic                        out_ready_i,
  output logic signed [ACC_BITS-1:0]  acc_o [4],
  output logic signed [COEF_BITS-1:0] coef_o [9],
  output logic signed [WORD_BITS-1:0] vec_o [3]
);

  localparam int QW = COEF_BITS - 2;
  localparam int PW = 2 * WORD_BITS;

  // Order of the truncated pairwise products of the configured quaternion.
  localparam int QXX = 0;
  localparam int QYY = 1;
  localparam int QZZ = 2;
  localparam int QWW = 3;
  localparam int QXY = 4;
  localparam int QXZ = 5;
  localparam int QYZ = 6;
  localparam int QXW = 7;
  localparam int QYW = 8;
  localparam int QZW = 9;

  stage_ctl_t                  s1_ctl_q, s2_ctl_q;
  logic                        s1_ready, s2_ready;
  logic signed [PW-1:0]        prod_d [4][4];
  logic signed [PW-1:0]        prod_q [4][4];
  logic signed [PW-1:0]        sq [10];
  logic signed [QW-1:0]        qq_d [10];
  logic signed [QW-1:0]        qq_q [10];
  logic signed [WORD_BITS-1:0] s1_vec_q [3];
  logic signed [ACC_BITS-1:0]  acc_d [4];
  logic signed [ACC_BITS-1:0]  acc_q [4];
  logic signed [COEF_BITS-1:0] coef_d [9];
  logic signed [COEF_BITS-1:0] coef_q [9];
  logic signed [WORD_BITS-1:0] s2_vec_q [3];

  assign s2_ready   = !s2_ctl_q.valid || out_ready_i;
  assign s1_ready   = !s1_ctl_q.valid || s2_ready;
  assign in_ready_o = s1_ready;

  // Stage 1: the full-precision Hamilton products and the truncated pairwise quaternion products.
  always_comb begin
    prod_d[0][0] = quat_i[3] * vec_i[0];
    prod_d[0][1] = quat_i[0] * vec_i[3];
    prod_d[0][2] = quat_i[1] * vec_i[2];
    prod_d[0][3] = quat_i[2] * vec_i[1];
    prod_d[1][0] = quat_i[3] * vec_i[1];
    prod_d[1][1] = quat_i[1] * vec_i[3];
    prod_d[1][2] = quat_i[2] * vec_i[0];
    prod_d[1][3] = quat_i[0] * vec_i[2];
    prod_d[2][0] = quat_i[3] * vec_i[2];
    prod_d[2][1] = quat_i[2] * vec_i[3];
    prod_d[2][2] = quat_i[0] * vec_i[1];
    prod_d[2][3] = quat_i[1] * vec_i[0];
    prod_d[3][0] = quat_i[3] * vec_i[3];
    prod_d[3][1] = quat_i[0] * vec_i[0];
    prod_d[3][2] = quat_i[1] * vec_i[1];
    prod_d[3][3] = quat_i[2] * vec_i[2];
    sq[QXX] = quat_i[0] * quat_i[0];
    sq[QYY] = quat_i[1] * quat_i[1];
    sq[QZZ] = quat_i[2] * quat_i[2];
    sq[QWW] = quat_i[3] * quat_i[3];
    sq[QXY] = quat_i[0] * quat_i[1];
    sq[QXZ] = quat_i[0] * quat_i[2];
    sq[QYZ] = quat_i[1] * quat_i[2];
    sq[QXW] = quat_i[0] * quat_i[3];
    sq[QYW] = quat_i[1] * quat_i[3];
    sq[QZW] = quat_i[2] * quat_i[3];
    for (int k = 0; k < 10; k++) begin
      qq_d[k] = QW'(sq[k] >>> FRAC_BITS);
    end
  end

  // Stage 2: Hamilton sums and the nine rotation matrix coefficients.
  always_comb begin
    for (int l = 0; l < 3; l++) begin
      acc_d[l] = ACC_BITS'(prod_q[l][0]) + ACC_BITS'(prod_q[l][1])
               + ACC_BITS'(prod_q[l][2]) - ACC_BITS'(prod_q[l][3]);
    end
    acc_d[3] = ACC_BITS'(prod_q[3][0]) - ACC_BITS'(prod_q[3][1])
             - ACC_BITS'(prod_q[3][2]) - ACC_BITS'(prod_q[3][3]);
    coef_d[0] = COEF_BITS'(qq_q[QXX]) - COEF_BITS'(qq_q[QYY])
              - COEF_BITS'(qq_q[QZZ]) + COEF_BITS'(qq_q[QWW]);
    coef_d[1] = COEF_BITS'(qq_q[QXY]) - COEF_BITS'(qq_q[QZW]);
    coef_d[2] = COEF_BITS'(qq_q[QXZ]) + COEF_BITS'(qq_q[QYW]);
    coef_d[3] = COEF_BITS'(qq_q[QXY]) + COEF_BITS'(qq_q[QZW]);
    coef_d[4] = COEF_BITS'(qq_q[QWW]) - COEF_BITS'(qq_q[QXX])
              + COEF_BITS'(qq_q[QYY]) - COEF_BITS'(qq_q[QZZ]);
    coef_d[5] = COEF_BITS'(qq_q[QYZ]) - COEF_BITS'(qq_q[QXW]);
    coef_d[6] = COEF_BITS'(qq_q[QXZ]) - COEF_BITS'(qq_q[QYW]);
    coef_d[7] = COEF_BITS'(qq_q[QXW]) + COEF_BITS'(qq_q[QYZ]);
    coef_d[8] = COEF_BITS'(qq_q[QWW]) - COEF_BITS'(qq_q[QXX])
              - COEF_BITS'(qq_q[QYY]) + COEF_BITS'(qq_q[QZZ]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_ctl_q <= CTL_IDLE;
      s2_ctl_q <= CTL_IDLE;
    end else begin
      if (s1_ready) begin
        s1_ctl_q <= in_ctl_i;
      end
      if (s2_ready) begin
        s2_ctl_q <= s1_ctl_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_ready) begin
      prod_q <= prod_d;
      qq_q   <= qq_d;
      for (int c = 0; c < 3; c++) begin
        s1_vec_q[c] <= vec_i[c];
      end
    end
    if (s2_ready) begin
      acc_q    <= acc_d;
      coef_q   <= coef_d;
      s2_vec_q <= s1_vec_q;
    end
  end

  assign out_ctl_o = s2_ctl_q;
  assign acc_o     = acc_q;
  assign coef_o    = coef_q;
  assign vec_o     = s2_vec_q;

endmodule

/* src/qrm_rotate.sv */
module qrm_rotate
  import qrm_pkg::*;
#(
  parameter int WORD_BITS = 16,
  parameter int COEF_BITS = 20,
  parameter int ACC_BITS  = 38
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  stage_ctl_t                  in_ctl_i,
  output logic                        in_ready_o,
  input  logic signed [ACC_BITS-1:0]  acc_i [4],
  input  logic signed [COEF_BITS-1:0] coef_i [9],
  input  logic signed [WORD_BITS-1:0] vec_i [3],
  output stage_ctl_t                  out_ctl_o,
  input  logic                        out_ready_i,
  output logic signed [ACC_BITS-1:0]  acc_o [4]
);

  // Each coefficient product is split into a low half (unsigned) and a high half (signed).
  localparam int HW  = (COEF_BITS + 1) / 2;
  localparam int LOW = WORD_BITS + HW + 1;
  localparam int HIW = WORD_BITS + COEF_BITS - HW;

  stage_ctl_t                 s3_ctl_q, s4_ctl_q;
  logic                       s3_ready, s4_ready;
  logic signed [LOW-1:0]      lo_d [9];
  logic signed [LOW-1:0]      lo_q [9];
  logic signed [HIW-1:0]      hi_d [9];
  logic signed [HIW-1:0]      hi_q [9];
  logic signed [ACC_BITS-1:0] mult_q [4];
  logic signed [ACC_BITS-1:0] term [9];
  logic signed [ACC_BITS-1:0] rot [3];
  logic signed [ACC_BITS-1:0] acc_d [4];
  logic signed [ACC_BITS-1:0] acc_q [4];

  assign s4_ready   = !s4_ctl_q.valid || out_ready_i;
  assign s3_ready   = !s3_ctl_q.valid || s4_ready;
  assign in_ready_o = s3_ready;

  // Stage 3: vector component times coefficient, as two partial products.
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        lo_d[3*r+c] = vec_i[c] * $signed({1'b0, coef_i[3*r+c][HW-1:0]});
        hi_d[3*r+c] = vec_i[c] * $signed(coef_i[3*r+c][COEF_BITS-1:HW]);
      end
    end
  end

  // Stage 4: recombine the partial products and form the rotated components.
  // In each row the diagonal term stays single and the two others are doubled.
  always_comb begin
    for (int k = 0; k < 9; k++) begin
      term[k] = (ACC_BITS'(hi_q[k]) <<< HW) + ACC_BITS'(lo_q[k]);
    end
    rot[0] = term[0] + ((term[1] + term[2]) <<< 1);
    rot[1] = term[4] + ((term[3] + term[5]) <<< 1);
    rot[2] = term[8] + ((term[6] + term[7]) <<< 1);
    unique case (s3_ctl_q.action)
      ACT_MULT: begin
        acc_d = mult_q;
      end
      ACT_ROT: begin
        for (int r = 0; r < 3; r++) begin
          acc_d[r] = rot[r];
        end
        acc_d[3] = '0;
      end
      default: begin
        acc_d = mult_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_ctl_q <= CTL_IDLE;
      s4_ctl_q <= CTL_IDLE;
    end else begin
      if (s3_ready) begin
        s3_ctl_q <= in_ctl_i;
      end
      if (s4_ready) begin
        s4_ctl_q <= s3_ctl_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s3_ready) begin
      lo_q   <= lo_d;
      hi_q   <= hi_d;
      mult_q <= acc_i;
    end
    if (s4_ready) begin
      acc_q <= acc_d;
    end
  end

  assign out_ctl_o = s4_ctl_q;
  assign acc_o     = acc_q;

endmodule

/* src/qrm_saturate.sv */
module qrm_saturate
  import qrm_pkg::*;
#(
  parameter int WORD_BITS = 16,
  parameter int FRAC_BITS = 14,
  parameter int ACC_BITS  = 38
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic signed [ACC_BITS-1:0]  acc_i [4],
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic signed [WORD_BITS-1:0] lane_o [4],
  output logic                        sat_o
);

  localparam logic [WORD_BITS-1:0] MAX_VAL = {1'b0, {(WORD_BITS-1){1'b1}}};
  localparam logic [WORD_BITS-1:0] MIN_VAL = {1'b1, {(WORD_BITS-1){1'b0}}};

  logic                         valid_q;
  logic                         ready;
  logic signed [ACC_BITS-1:0]   shifted [4];
  logic [ACC_BITS-WORD_BITS:0]  upper [4];
  logic [3:0]                   fits;
  logic signed [WORD_BITS-1:0]  lane_d [4];
  logic signed [WORD_BITS-1:0]  lane_q [4];
  logic                         sat_q;

  assign ready      = !valid_q || out_ready_i;
  assign in_ready_o = ready;

  // A value fits when all bits from the output sign bit upward agree.
  always_comb begin
    for (int l = 0; l < 4; l++) begin
      shifted[l] = acc_i[l] >>> FRAC_BITS;
      upper[l]   = shifted[l][ACC_BITS-1:WORD_BITS-1];
      fits[l]    = (&upper[l]) || !(|upper[l]);
      if (fits[l]) begin
        lane_d[l] = shifted[l][WORD_BITS-1:0];
      end else if (shifted[l][ACC_BITS-1]) begin
        lane_d[l] = MIN_VAL;
      end else begin
        lane_d[l] = MAX_VAL;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready) begin
      lane_q <= lane_d;
      sat_q  <= !(&fits);
    end
  end

  assign out_valid_o = valid_q;
  assign lane_o      = lane_q;
  assign sat_o       = sat_q;

endmodule

/* src/quaternion_rotate_and_multiply.sv */
// Fixed-point quaternion unit. With tuser 0 the input is a quaternion and the result is the
// Hamilton product of the configured quaternion and the input; with tuser 1 the input is an
// integer vector rotated (and scaled, if the quaternion is not unit length) by the configured
// quaternion, and out_w is zero. Results are shifted down by FRAC_BITS, saturated, and the
// result tuser flags any clipping. The pipeline has five register stages: one product stage,
// one sum stage, one coefficient multiply stage, one recombine stage and the saturating output
// register. It takes one transaction per cycle while the output is not stalled, and a stalled
// output only holds up the stages behind it that are full. Configuration writes are taken every
// cycle and apply to inputs accepted after them; the reset quaternion is the identity.
module quaternion_rotate_and_multiply
  import qrm_pkg::*;
#(
  parameter int WORD_BITS = 16,
  parameter int FRAC_BITS = 14,
  localparam int TDATA_W = ((4 * WORD_BITS + 7) / 8) * 8
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [CFG_IDX_BITS-1:0] cfg_index_i,
  input  logic [WORD_BITS-1:0]    cfg_data_i,
  input  logic                    s_axis_tvalid,
  output logic                    s_axis_tready,
  input  logic [TDATA_W-1:0]      s_axis_tdata,  // in_x, in_y, in_z, in_w
  input  logic                    s_axis_tuser,  // action
  output logic                    m_axis_tvalid,
  input  logic                    m_axis_tready,
  output logic [TDATA_W-1:0]      m_axis_tdata,  // out_x, out_y, out_z, out_w
  output logic                    m_axis_tuser   // saturated
);

  localparam int QUAD_W  = (2 * WORD_BITS > FRAC_BITS) ? 2 * WORD_BITS - FRAC_BITS : 1;
  localparam int COEF_W  = QUAD_W + 2;
  localparam int ACC_A   = 2 * WORD_BITS + 2;
  localparam int ACC_B   = WORD_BITS + COEF_W + 2;
  localparam int ACC_M   = (ACC_A > ACC_B) ? ACC_A : ACC_B;
  localparam int ACC_W   = (ACC_M > 64) ? 64 : ACC_M;
  localparam logic [WORD_BITS-1:0] ONE_Q = WORD_BITS'(64'd1 << FRAC_BITS);

  logic signed [WORD_BITS-1:0] quat_q [4];
  logic signed [WORD_BITS-1:0] in_lane [4];
  stage_ctl_t                  in_ctl;
  stage_ctl_t                  front_ctl, rot_ctl;
  logic                        front_ready, rot_ready, sat_ready;
  logic signed [ACC_W-1:0]     front_acc [4];
  logic signed [COEF_W-1:0]    front_coef [9];
  logic signed [WORD_BITS-1:0] front_vec [3];
  logic signed [ACC_W-1:0]     rot_acc [4];
  logic signed [WORD_BITS-1:0] out_lane [4];

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quat_q[0] <= '0;
      quat_q[1] <= '0;
      quat_q[2] <= '0;
      quat_q[3] <= ONE_Q;
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_QUAT_X: quat_q[0] <= cfg_data_i;
        REG_QUAT_Y: quat_q[1] <= cfg_data_i;
        REG_QUAT_Z: quat_q[2] <= cfg_data_i;
        REG_QUAT_W: quat_q[3] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int l = 0; l < 4; l++) begin
      in_lane[l] = s_axis_tdata[l*WORD_BITS +: WORD_BITS];
    end
  end

  assign in_ctl        = '{valid: s_axis_tvalid, action: action_e'(s_axis_tuser)};
  assign s_axis_tready = front_ready;

  qrm_front #(
    .WORD_BITS (WORD_BITS),
    .FRAC_BITS (FRAC_BITS),
    .COEF_BITS (COEF_W),
    .ACC_BITS  (ACC_W)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_ctl_i    (in_ctl),
    .in_ready_o  (front_ready),
    .quat_i      (quat_q),
    .vec_i       (in_lane),
    .out_ctl_o   (front_ctl),
    .out_ready_i (rot_ready),
    .acc_o       (front_acc),
    .coef_o      (front_coef),
    .vec_o       (front_vec)
  );

  qrm_rotate #(
    .WORD_BITS (WORD_BITS),
    .COEF_BITS (COEF_W),
    .ACC_BITS  (ACC_W)
  ) u_rotate (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_ctl_i    (front_ctl),
    .in_ready_o  (rot_ready),
    .acc_i       (front_acc),
    .coef_i      (front_coef),
    .vec_i       (front_vec),
    .out_ctl_o   (rot_ctl),
    .out_ready_i (sat_ready),
    .acc_o       (rot_acc)
  );

  qrm_saturate #(
    .WORD_BITS (WORD_BITS),
    .FRAC_BITS (FRAC_BITS),
    .ACC_BITS  (ACC_W)
  ) u_saturate (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (rot_ctl.valid),
    .in_ready_o  (sat_ready),
    .acc_i       (rot_acc),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .lane_o      (out_lane),
    .sat_o       (m_axis_tuser)
  );

  assign m_axis_tdata = TDATA_W'({out_lane[3], out_lane[2], out_lane[1], out_lane[0]});

endmodule

/* src/qrm_checker.sv */
module qrm_checker
  import qrm_pkg::*;
#(
  parameter int TDATA_W = 64
) (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               s_axis_tvalid,
  input logic               s_axis_tready,
  input logic               m_axis_tvalid,
  input logic               m_axis_tready,
  input logic [TDATA_W-1:0] m_axis_tdata,
  input logic               m_axis_tuser
);

  localparam int CNT_W = $clog2(PIPE_DEPTH + 1);

  logic             in_acc, out_acc, flow;
  logic [CNT_W-1:0] inflight_d, inflight_q;

  assign in_acc     = s_axis_tvalid && s_axis_tready;
  assign out_acc    = m_axis_tvalid && m_axis_tready;
  assign flow       = m_axis_tready && rst_ni;
  assign inflight_d = inflight_q + CNT_W'(in_acc) - CNT_W'(out_acc);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inflight_q <= '0;
    end else begin
      inflight_q <= inflight_d;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled result changed or dropped");

  // With the output side ready every stage moves, so the input side must be ready too.
  a_ready_through: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tready |-> s_axis_tready)
    else $error("input stalled while output side ready");

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(in_acc && rst_ni, PIPE_DEPTH) && $past(flow, 4) && $past(flow, 3)
      && $past(flow, 2) && $past(flow, 1) |-> m_axis_tvalid)
    else $error("result missing after pipeline latency");

  a_no_invented: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> inflight_q != '0)
    else $error("result shown with no transaction in flight");

  a_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    inflight_q <= CNT_W'(PIPE_DEPTH))
    else $error("more transactions in flight than pipeline stages");

endmodule

bind quaternion_rotate_and_multiply qrm_checker #(.TDATA_W(TDATA_W)) u_qrm_checker (.*);

/* test/quat_result_checker.sv */
module quat_result_checker
  import qrm_pkg::*;
#(
  parameter int WORD_BITS = 16,
  parameter int FRAC_BITS = 14
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_valid_i,
  input  logic                    cfg_ready_i,
  input  logic [CFG_IDX_BITS-1:0] cfg_index_i,
  input  logic [WORD_BITS-1:0]    cfg_data_i,
  input  logic                    s_tvalid_i,
  input  logic                    s_tready_i,
  input  logic [4*WORD_BITS-1:0]  s_tdata_i,  // in_x, in_y, in_z, in_w
  input  logic                    s_tuser_i,  // action
  input  logic                    m_tvalid_i,
  input  logic                    m_tready_i,
  input  logic [4*WORD_BITS-1:0]  m_tdata_i,  // out_x, out_y, out_z, out_w
  input  logic                    m_tuser_i,  // saturated
  output int unsigned             fail_count_o,
  output int unsigned             pending_o,
  output int unsigned             sat_count_o
);

  localparam longint WORD_MAX = (longint'(1) <<< (WORD_BITS - 1)) - 1;
  localparam longint WORD_MIN = -(longint'(1) <<< (WORD_BITS - 1));
  localparam int     MAX_REPORTS = 10;

  // Packed so that x lands in the lowest bits of tdata.
  typedef struct packed {
    logic signed [WORD_BITS-1:0] w;
    logic signed [WORD_BITS-1:0] z;
    logic signed [WORD_BITS-1:0] y;
    logic signed [WORD_BITS-1:0] x;
  } quat4_t;

  typedef struct packed {
    quat4_t val;
    logic   sat;
  } quat_result_t;

  quat4_t       held_quat;
  quat_result_t expected_results[$];
  int unsigned  results_seen;

  function automatic logic [WORD_BITS:0] clip_to_word(input longint acc);
    longint v;
    v = acc >>> FRAC_BITS;
    if (v < WORD_MIN) return {1'b1, WORD_MIN[WORD_BITS-1:0]};
    if (v > WORD_MAX) return {1'b1, WORD_MAX[WORD_BITS-1:0]};
    return {1'b0, v[WORD_BITS-1:0]};
  endfunction

  function automatic quat_result_t predict_quat_unit(input quat4_t q, input action_e act,
                                                     input quat4_t a);
    longint qx, qy, qz, qw, ax, ay, az, aw;
    longint xx, yy, zz, ww, xy, xz, yz, xw, yw, zw;
    longint acc_x, acc_y, acc_z, acc_w;
    logic [WORD_BITS:0] sx, sy, sz, sw;
    quat_result_t r;
    qx = q.x;
    qy = q.y;
    qz = q.z;
    qw = q.w;
    ax = a.x;
    ay = a.y;
    az = a.z;
    aw = a.w;
    if (act == ACT_MULT) begin
      acc_x = qw * ax + qx * aw + qy * az - qz * ay;
      acc_y = qw * ay + qy * aw + qz * ax - qx * az;
      acc_z = qw * az + qz * aw + qx * ay - qy * ax;
      acc_w = qw * aw - qx * ax - qy * ay - qz * az;
      sw = clip_to_word(acc_w);
    end else begin
      // Pairwise products are floored to the Q format before the matrix is formed.
      xx = (qx * qx) >>> FRAC_BITS;
      yy = (qy * qy) >>> FRAC_BITS;
      zz = (qz * qz) >>> FRAC_BITS;
      ww = (qw * qw) >>> FRAC_BITS;
      xy = (qx * qy) >>> FRAC_BITS;
      xz = (qx * qz) >>> FRAC_BITS;
      yz = (qy * qz) >>> FRAC_BITS;
      xw = (qx * qw) >>> FRAC_BITS;
      yw = (qy * qw) >>> FRAC_BITS;
      zw = (qz * qw) >>> FRAC_BITS;
      acc_x = ax * (xx - yy - zz + ww) + (ay * (xy - zw) + az * (xz + yw)) * 2;
      acc_y = ay * (ww - xx + yy - zz) + (ax * (xy + zw) + az * (yz - xw)) * 2;
      acc_z = az * (ww - xx - yy + zz) + (ax * (xz - yw) + ay * (xw + yz)) * 2;
      sw = '0;
    end
    sx = clip_to_word(acc_x);
    sy = clip_to_word(acc_y);
    sz = clip_to_word(acc_z);
    r.val.x = sx[WORD_BITS-1:0];
    r.val.y = sy[WORD_BITS-1:0];
    r.val.z = sz[WORD_BITS-1:0];
    r.val.w = sw[WORD_BITS-1:0];
    r.sat   = sx[WORD_BITS] | sy[WORD_BITS] | sz[WORD_BITS] | sw[WORD_BITS];
    return r;
  endfunction

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
    sat_count_o  = 0;
    results_seen = 0;
    held_quat    = '{w: 16'sd16384, z: '0, y: '0, x: '0};
  end

  always @(posedge clk_i) begin
    quat_result_t exp_r;
    quat4_t       got;
    if (!rst_ni) begin
      held_quat = '{w: 16'sd16384, z: '0, y: '0, x: '0};
    end else begin
      // Results are checked before this edge's input is queued.
      if (m_tvalid_i && m_tready_i) begin
        got = quat4_t'(m_tdata_i);
        results_seen++;
        if (m_tuser_i) sat_count_o++;
        if (expected_results.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= MAX_REPORTS)
            $display("unexpected result %0d: x=%0d y=%0d z=%0d w=%0d sat=%0b",
                     results_seen, got.x, got.y, got.z, got.w, m_tuser_i);
        end else begin
          exp_r = expected_results.pop_front();
          if (got.x !== exp_r.val.x || got.y !== exp_r.val.y || got.z !== exp_r.val.z ||
              got.w !== exp_r.val.w || m_tuser_i !== exp_r.sat) begin
            fail_count_o++;
            if (fail_count_o <= MAX_REPORTS) begin
              $display("result %0d mismatch: expected x=%0d y=%0d z=%0d w=%0d sat=%0b",
                       results_seen, exp_r.val.x, exp_r.val.y, exp_r.val.z, exp_r.val.w,
                       exp_r.sat);
              $display("  got x=%0d y=%0d z=%0d w=%0d sat=%0b",
                       got.x, got.y, got.z, got.w, m_tuser_i);
            end
          end
        end
      end
      // An input taken at the same edge as a register write still sees the old quaternion.
      if (s_tvalid_i && s_tready_i)
        expected_results.push_back(predict_quat_unit(held_quat, action_e'(s_tuser_i),
                                                     quat4_t'(s_tdata_i)));
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_reg_e'(cfg_index_i))
          REG_QUAT_X: held_quat.x = cfg_data_i;
          REG_QUAT_Y: held_quat.y = cfg_data_i;
          REG_QUAT_Z: held_quat.z = cfg_data_i;
          REG_QUAT_W: held_quat.w = cfg_data_i;
          default: ;
        endcase
      end
    end
    pending_o = expected_results.size();
  end

endmodule

/* test/quaternion_rotate_and_multiply_tb.sv */
module quaternion_rotate_and_multiply_tb;
  import qrm_pkg::*;

  localparam int WORD_BITS  = 16;
  localparam int FRAC_BITS  = 14;
  localparam int TDATA_W    = 4 * WORD_BITS;
  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 300;
  localparam int RAND_SETTINGS = 6;
  localparam int ITEMS_PER_SETTING = 135;

  localparam logic [WORD_BITS-1:0] W_MAX  = 16'h7fff;
  localparam logic [WORD_BITS-1:0] W_MIN  = 16'h8000;
  localparam logic [WORD_BITS-1:0] W_ONE  = 16'h4000;
  localparam logic [WORD_BITS-1:0] W_MONE = 16'hc000;
  localparam logic [WORD_BITS-1:0] W_HALF_SQRT2 = 16'h2d41;

  logic                    clk_i = 1'b0;
  logic                    rst_ni;
  logic                    cfg_valid_i;
  logic                    cfg_ready_o;
  logic [CFG_IDX_BITS-1:0] cfg_index_i;
  logic [WORD_BITS-1:0]    cfg_data_i;
  logic                    s_axis_tvalid;
  logic                    s_axis_tready;
  logic [TDATA_W-1:0]      s_axis_tdata;  // in_x, in_y, in_z, in_w
  logic                    s_axis_tuser;  // action
  logic                    m_axis_tvalid;
  logic                    m_axis_tready;
  logic [TDATA_W-1:0]      m_axis_tdata;  // out_x, out_y, out_z, out_w
  logic                    m_axis_tuser;  // saturated

  int unsigned fail_count;
  int unsigned pending;
  int unsigned sat_count;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned hold_requests = 0;
  int unsigned cycle_count = 0;
  int unsigned mult_items = 0;
  int unsigned rot_items = 0;
  int unsigned quat_settings = 0;

  quaternion_rotate_and_multiply #(
    .WORD_BITS(WORD_BITS),
    .FRAC_BITS(FRAC_BITS)
  ) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  quat_result_checker #(
    .WORD_BITS(WORD_BITS),
    .FRAC_BITS(FRAC_BITS)
  ) checker_i (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_i (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .s_tvalid_i  (s_axis_tvalid),
    .s_tready_i  (s_axis_tready),
    .s_tdata_i   (s_axis_tdata),
    .s_tuser_i   (s_axis_tuser),
    .m_tvalid_i  (m_axis_tvalid),
    .m_tready_i  (m_axis_tready),
    .m_tdata_i   (m_axis_tdata),
    .m_tuser_i   (m_axis_tuser),
    .fail_count_o(fail_count),
    .pending_o   (pending),
    .sat_count_o (sat_count)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Test completed with failures");
    $finish;
  end

  // Output side: random back pressure, plus long hold-offs on request.
  initial begin
    int unsigned hold_left;
    int unsigned hold_served;
    hold_left = 0;
    hold_served = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_served != hold_requests) begin
        hold_served = hold_requests;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        m_axis_tready <= 1'b0;
        hold_left--;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after the transaction.
  task automatic send_item(input action_e act, input logic [WORD_BITS-1:0] vx,
                           input logic [WORD_BITS-1:0] vy, input logic [WORD_BITS-1:0] vz,
                           input logic [WORD_BITS-1:0] vw);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {vw, vz, vy, vx};
    s_axis_tuser  <= act;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
    if (act == ACT_MULT) mult_items++;
    else rot_items++;
  endtask

  // Stops offering input and waits out every outstanding result and the pipeline.
  task automatic wait_results_done();
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (PIPE_DEPTH + 2) @(negedge clk_i);
  endtask

  task automatic set_quat(input logic [WORD_BITS-1:0] qx, input logic [WORD_BITS-1:0] qy,
                          input logic [WORD_BITS-1:0] qz, input logic [WORD_BITS-1:0] qw);
    cfg_reg_e             regs[4];
    logic [WORD_BITS-1:0] vals[4];
    regs[0] = REG_QUAT_X;
    regs[1] = REG_QUAT_Y;
    regs[2] = REG_QUAT_Z;
    regs[3] = REG_QUAT_W;
    vals[0] = qx;
    vals[1] = qy;
    vals[2] = qz;
    vals[3] = qw;
    for (int i = 0; i < 4; i++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= regs[i];
      cfg_data_i  <= vals[i];
      do @(posedge clk_i); while (!cfg_ready_o);
      @(negedge clk_i);
    end
    cfg_valid_i <= 1'b0;
    quat_settings++;
  endtask

  function automatic logic [WORD_BITS-1:0] rand_word();
    return WORD_BITS'($urandom());
  endfunction

  function automatic logic [WORD_BITS-1:0] rand_near_unit();
    return WORD_BITS'($urandom_range(23170) - 11585);
  endfunction

  function automatic logic [WORD_BITS-1:0] pick_component(input int unsigned mode);
    logic [WORD_BITS-1:0] corners[6];
    corners[0] = W_MAX;
    corners[1] = W_MIN;
    corners[2] = '0;
    corners[3] = '1;
    corners[4] = W_ONE;
    corners[5] = W_MONE;
    case (mode)
      0, 1: return rand_word();
      2: return WORD_BITS'($urandom_range(8192) - 4096);
      default: return corners[3'($urandom_range(5))];
    endcase
  endfunction

  initial begin
    int unsigned qmode;
    int unsigned fmode;
    action_e     act;
    rst_ni        = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = REG_QUAT_X;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = ACT_MULT;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    send_idle_pct = 12;
    recv_idle_pct = 47;

    // Identity quaternion straight out of reset; in_w must be ignored when rotating.
    send_item(ACT_MULT, '0, '0, '0, '0);
    send_item(ACT_MULT, W_MAX, W_MAX, W_MAX, W_MAX);
    send_item(ACT_MULT, W_MIN, W_MIN, W_MIN, W_MIN);
    send_item(ACT_ROT, W_MAX, W_MIN, 16'h1234, W_MIN);
    send_item(ACT_ROT, W_MIN, W_MIN, W_MIN, W_MAX);

    // Most negative quaternion: both modes overflow and saturate.
    wait_results_done();
    set_quat(W_MIN, W_MIN, W_MIN, W_MIN);
    send_item(ACT_MULT, W_MAX, W_MAX, W_MAX, W_MAX);
    send_item(ACT_MULT, W_MIN, W_MIN, W_MIN, W_MIN);
    send_item(ACT_ROT, 16'd1, 16'd1, 16'd1, '0);
    send_item(ACT_ROT, W_MAX, W_MAX, W_MAX, W_MAX);
    send_item(ACT_MULT, W_ONE, '0, W_MONE, W_MAX);

    // Most positive quaternion: far from unit length, so rotation also scales.
    wait_results_done();
    set_quat(W_MAX, W_MAX, W_MAX, W_MAX);
    send_item(ACT_ROT, 16'd100, 16'd200, 16'd300, W_MIN);
    send_item(ACT_ROT, W_MIN, W_MAX, '0, '0);
    send_item(ACT_MULT, W_MAX, W_MIN, W_MAX, W_MIN);
    send_item(ACT_MULT, '1, '1, '1, '1);

    // Quarter turn about z.
    wait_results_done();
    set_quat('0, '0, W_HALF_SQRT2, W_HALF_SQRT2);
    send_item(ACT_ROT, 16'd1000, '0, '0, '0);
    send_item(ACT_ROT, '0, 16'd1000, '0, '0);
    send_item(ACT_ROT, '0, '0, W_MIN, '0);
    send_item(ACT_MULT, W_ONE, '0, '0, W_ONE);

    // Half-length components on every axis.
    wait_results_done();
    set_quat(16'h2000, 16'h2000, 16'h2000, 16'h2000);
    send_item(ACT_ROT, 16'd4096, W_MONE, 16'd17, '1);
    send_item(ACT_MULT, W_ONE, '0, '0, '0);

    for (int s = 0; s < RAND_SETTINGS; s++) begin
      case (s / 2)
        0: begin
          send_idle_pct = 12;
          recv_idle_pct = 47;
        end
        1: begin
          send_idle_pct = 47;
          recv_idle_pct = 12;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      wait_results_done();
      qmode = $urandom_range(2);
      if (s == 0) set_quat(W_MIN, W_MIN, W_MIN, W_MIN);
      else if (s == 1) set_quat(W_MAX, W_MAX, W_MAX, W_MAX);
      else if (qmode == 0) set_quat(rand_word(), rand_word(), rand_word(), rand_word());
      else set_quat(rand_near_unit(), rand_near_unit(), rand_near_unit(), rand_near_unit());
      for (int n = 0; n < ITEMS_PER_SETTING; n++) begin
        // Stall the output long enough for the pipeline to fill and block the input.
        if (s == 0 && n == 40) hold_requests++;
        if (s == 2 && n == 60) wait_results_done();
        act = action_e'($urandom_range(1));
        fmode = $urandom_range(3);
        send_item(act, pick_component(fmode), pick_component(fmode),
                  pick_component(fmode), pick_component(fmode));
      end
    end

    wait_results_done();
    $display("Covered %0d multiplies, %0d rotations, %0d quaternion settings, %0d saturated.",
             mult_items, rot_items, quat_settings, sat_count);
    $display("Traffic ran with sender and receiver gaps, a long output stall and a full drain.");
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
